// ===== design/mstt_pkg.sv =====
// Shared constants and types for the multi-slot timeout timer.
// No dependencies; imported by mstt_expiry and the top level.
package mstt_pkg;

    localparam int SLOTS     = 8;
    localparam int TIME_BITS = 32;
    localparam int MAX_OUT   = 8;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_OUT + 1);
    localparam int IDX_W     = SLOT_W + 1;

    typedef enum logic [2:0] {
        FUNC_REGISTER = 3'd0,
        FUNC_START    = 3'd1,
        FUNC_STOP     = 3'd2,
        FUNC_DELETE   = 3'd3,
        FUNC_TICK     = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

endpackage

// ===== design/mstt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mstt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/mstt_expiry.sv =====
// Shared expiry compare: modular elapsed time against slot duration.
// Depends on mstt_pkg.
module mstt_expiry
    import mstt_pkg::*;
(
    input  logic                 i_en,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic [TIME_BITS-1:0] i_begin,
    input  logic [TIME_BITS-1:0] i_length,
    output logic                 o_hit
);

    logic [TIME_BITS-1:0] elapsed;

    // wraps modulo 2^TIME_BITS
    assign elapsed = i_now - i_begin;
    assign o_hit   = i_en && (elapsed > i_length);

endmodule

// ===== design/multi_slot_timeout_timer.sv =====
// Top level of the multi-slot timeout timer: command decode, slot scan, result queue.
// Depends on mstt_pkg, mstt_ram and mstt_expiry.
//
// Usage: the input channel (i_valid / o_stall) carries one command per
// transaction: register, start, stop, delete or tick. The output channel
// (o_valid / i_stall) carries register replies and timeout events; o_last
// marks the final result of a command.
// Start, stop, delete and unknown codes complete in the accept cycle and
// produce nothing. Register produces one reply, loaded into the output
// register from the emit state once the output register is free.
// A tick walks the slots through one compare unit, one slot per cycle, with
// each slot's duration and start time read from the RAMs in the cycle before
// its compare. After the scan, one event per expired slot goes out in slot order.
// o_stall is high from the cycle after accept until the last result has been
// loaded into the output register (or the scan ends with nothing expired).
// A stalled receiver holds the output register and pauses the event hand-out.
// Reset (synchronous, active low) frees every slot and empties the output.
module multi_slot_timeout_timer
    import mstt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [2:0]           i_func,
    input  logic [2:0]           i_slot_id,
    input  logic [TIME_BITS-1:0] i_duration,
    input  logic                 i_periodic,
    input  logic [TIME_BITS-1:0] i_now_time,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_kind,
    output logic [2:0]           o_result_slot,
    output logic                 o_ok,
    output logic                 o_last
);

    t_state               r_state, n_state;
    logic [SLOTS-1:0]     r_used, n_used;
    logic [SLOTS-1:0]     r_armed, n_armed;
    logic [SLOTS-1:0]     r_repeat, n_repeat;
    logic [SLOTS-1:0]     r_mask, n_mask;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_chk_vld, n_chk_vld;
    logic [SLOT_W-1:0]    r_chk_idx, n_chk_idx;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic                 r_is_reply, n_is_reply;
    logic [SLOT_W-1:0]    r_reply_slot, n_reply_slot;
    logic                 r_reply_ok, n_reply_ok;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_kind, n_out_kind;
    logic [2:0]           r_out_slot, n_out_slot;
    logic                 r_out_ok, n_out_ok;
    logic                 r_out_last, n_out_last;

    logic                 acc;
    logic                 id_ok;
    logic [SLOT_W-1:0]    id;
    logic                 free_found;
    logic [SLOT_W-1:0]    free_idx;
    logic [SLOT_W-1:0]    pick_idx;
    logic                 out_free;
    logic [SLOTS-1:0]     mask_left;

    logic                 len_we;
    logic [SLOT_W-1:0]    len_waddr;
    logic                 beg_we;
    logic [SLOT_W-1:0]    beg_waddr;
    logic [TIME_BITS-1:0] beg_wdata;
    logic [SLOT_W-1:0]    rd_addr;
    logic [TIME_BITS-1:0] len_rdata;
    logic [TIME_BITS-1:0] beg_rdata;
    logic                 cmp_en;
    logic                 cmp_hit;

    assign o_stall  = (r_state != S_IDLE);
    assign acc      = i_valid && !o_stall;
    assign id       = i_slot_id[SLOT_W-1:0];
    assign id_ok    = (32'(i_slot_id) < 32'(SLOTS));
    assign out_free = !r_out_valid || !i_stall;

    // lowest free slot for register
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // lowest pending timeout
    always_comb begin
        pick_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                pick_idx = SLOT_W'(i);
            end
        end
    end

    assign mask_left = r_mask & ~(SLOTS'(1) << pick_idx);

    assign rd_addr = r_idx[SLOT_W-1:0];
    assign cmp_en  = r_chk_vld && r_used[r_chk_idx] && r_armed[r_chk_idx]
                     && (r_cnt < CNT_W'(MAX_OUT));

    mstt_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (SLOTS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (i_duration),
        .i_raddr (rd_addr),
        .o_rdata (len_rdata)
    );

    mstt_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (SLOTS)
    ) u_beg_ram (
        .i_clk   (i_clk),
        .i_we    (beg_we),
        .i_waddr (beg_waddr),
        .i_wdata (beg_wdata),
        .i_raddr (rd_addr),
        .o_rdata (beg_rdata)
    );

    mstt_expiry u_expiry (
        .i_en     (cmp_en),
        .i_now    (r_now),
        .i_begin  (beg_rdata),
        .i_length (len_rdata),
        .o_hit    (cmp_hit)
    );

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_armed      = r_armed;
        n_repeat     = r_repeat;
        n_mask       = r_mask;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_chk_vld    = r_chk_vld;
        n_chk_idx    = r_chk_idx;
        n_now        = r_now;
        n_is_reply   = r_is_reply;
        n_reply_slot = r_reply_slot;
        n_reply_ok   = r_reply_ok;
        n_out_valid  = r_out_valid && i_stall;
        n_out_kind   = r_out_kind;
        n_out_slot   = r_out_slot;
        n_out_ok     = r_out_ok;
        n_out_last   = r_out_last;
        len_we       = 1'b0;
        len_waddr    = free_idx;
        beg_we       = 1'b0;
        beg_waddr    = id;
        beg_wdata    = i_now_time;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (i_func)
                        FUNC_REGISTER: begin
                            n_is_reply   = 1'b1;
                            n_reply_ok   = free_found;
                            n_reply_slot = free_found ? free_idx : '0;
                            if (free_found) begin
                                len_we             = 1'b1;
                                n_used[free_idx]   = 1'b1;
                                n_armed[free_idx]  = 1'b0;
                                n_repeat[free_idx] = i_periodic;
                            end
                            n_state = S_EMIT;
                        end
                        FUNC_START: begin
                            if (id_ok && r_used[id]) begin
                                beg_we      = 1'b1;
                                n_armed[id] = 1'b1;
                            end
                        end
                        FUNC_STOP: begin
                            if (id_ok && r_used[id]) begin
                                n_armed[id] = 1'b0;
                            end
                        end
                        FUNC_DELETE: begin
                            // stored times are dead once the slot is free
                            if (id_ok && r_used[id]) begin
                                n_used[id]   = 1'b0;
                                n_armed[id]  = 1'b0;
                                n_repeat[id] = 1'b0;
                            end
                        end
                        FUNC_TICK: begin
                            n_now      = i_now_time;
                            n_is_reply = 1'b0;
                            n_mask     = '0;
                            n_cnt      = '0;
                            n_idx      = '0;
                            n_chk_vld  = 1'b0;
                            n_state    = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // issue next read, check the slot whose data is on the RAM output
                if (r_idx < IDX_W'(SLOTS)) begin
                    n_idx     = r_idx + IDX_W'(1);
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_idx[SLOT_W-1:0];
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (cmp_hit) begin
                    n_mask[r_chk_idx] = 1'b1;
                    n_cnt             = r_cnt + CNT_W'(1);
                    if (r_repeat[r_chk_idx]) begin
                        beg_we    = 1'b1;
                        beg_waddr = r_chk_idx;
                        beg_wdata = r_now;
                    end else begin
                        n_armed[r_chk_idx] = 1'b0;
                    end
                end
                if (r_chk_vld && (32'(r_chk_idx) == SLOTS - 1)) begin
                    n_state = (n_mask != '0) ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_is_reply) begin
                        n_out_kind = 1'b0;
                        n_out_slot = 3'(r_reply_slot);
                        n_out_ok   = r_reply_ok;
                        n_out_last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_out_kind = 1'b1;
                        n_out_slot = 3'(pick_idx);
                        n_out_ok   = 1'b1;
                        n_out_last = (mask_left == '0);
                        n_mask     = mask_left;
                        if (mask_left == '0) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_armed     <= '0;
            r_repeat    <= '0;
            r_mask      <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_chk_vld   <= 1'b0;
            r_is_reply  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_armed     <= n_armed;
            r_repeat    <= n_repeat;
            r_mask      <= n_mask;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_chk_vld   <= n_chk_vld;
            r_is_reply  <= n_is_reply;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx    <= n_chk_idx;
        r_now        <= n_now;
        r_reply_slot <= n_reply_slot;
        r_reply_ok   <= n_reply_ok;
        r_out_kind   <= n_out_kind;
        r_out_slot   <= n_out_slot;
        r_out_ok     <= n_out_ok;
        r_out_last   <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_result_slot = r_out_slot;
    assign o_ok          = r_out_ok;
    assign o_last        = r_out_last;

`ifndef ASSERT_OFF
    a_armed_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_armed & ~r_used) == '0)
        else $error("armed slot is not in use");

    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ($countones(r_mask) == 32'(r_cnt)))
        else $error("expiry count disagrees with pending mask");

    a_emit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_is_reply) |-> (r_mask != '0))
        else $error("event hand-out with nothing pending");

    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_kind) |-> r_out_last)
        else $error("register reply not marked last");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && (r_is_reply || mask_left == '0))
        |=> (r_state == S_IDLE && r_out_valid && r_out_last))
        else $error("final result did not return the block to idle");
`endif

endmodule
